@@ design/hrsp_pkg.sv @@
package hrsp_pkg;

   localparam int unsigned MaxResults = 3;
   localparam int unsigned QueueDepth = 2;
   localparam logic [31:0] MaxBodyLengthReset = 32'd10485760;

   localparam logic [1:0] KindData     = 2'd0;
   localparam logic [1:0] KindFieldEnd = 2'd1;
   localparam logic [1:0] KindDone     = 2'd2;
   localparam logic [1:0] KindError    = 2'd3;

   localparam logic [2:0] FieldMethod = 3'd0;
   localparam logic [2:0] FieldPath   = 3'd1;
   localparam logic [2:0] FieldQuery  = 3'd2;
   localparam logic [2:0] FieldName   = 3'd3;
   localparam logic [2:0] FieldValue  = 3'd4;
   localparam logic [2:0] FieldBody   = 3'd5;

   localparam logic [3:0] PhMethod  = 4'd0;
   localparam logic [3:0] PhPath    = 4'd1;
   localparam logic [3:0] PhQuery   = 4'd2;
   localparam logic [3:0] PhVersion = 4'd3;
   localparam logic [3:0] PhName    = 4'd4;
   localparam logic [3:0] PhSkip    = 4'd5;
   localparam logic [3:0] PhValue   = 4'd6;
   localparam logic [3:0] PhBody    = 4'd7;
   localparam logic [3:0] PhDone    = 4'd8;
   localparam logic [3:0] PhError   = 4'd9;

   localparam logic [3:0] NoMatch = 4'd15;
   localparam logic [3:0] ClLen   = 4'd14;
   localparam logic [32:0] LenSat = 33'h1_0000_0000;

   localparam logic [7:0] ChSpace    = 8'h20;
   localparam logic [7:0] ChQuestion = 8'h3F;
   localparam logic [7:0] ChColon    = 8'h3A;
   localparam logic [7:0] ChCr       = 8'h0D;
   localparam logic [7:0] ChLf       = 8'h0A;
   localparam logic [7:0] ChZero     = 8'h30;
   localparam logic [7:0] ChNine     = 8'h39;

   typedef struct packed {
      logic [3:0]  phase;
      logic        cr_pending;
      logic        body_wanted;
      logic [2:0]  method_match;
      logic [3:0]  name_match_index;
      logic [1:0]  skip_count;
      logic        length_present;
      logic        length_bad;
      logic [32:0] length_value;
      logic [31:0] body_remaining;
      logic        line_empty;
   } state_type;

   localparam state_type StateReset = '{
      phase: PhMethod, cr_pending: 1'b0, body_wanted: 1'b0, method_match: 3'b111,
      name_match_index: 4'd0, skip_count: 2'd0, length_present: 1'b0,
      length_bad: 1'b0, length_value: 33'd0, body_remaining: 32'd0, line_empty: 1'b1};

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] field;
      logic [7:0] out_byte;
   } result_type;

   typedef struct packed {
      state_type  st;
      logic       emit;
      result_type res;
   } step_type;

   typedef struct packed {
      result_type [MaxResults-1:0] res;
      logic [1:0]                  count;
      logic [31:0]                 blen;
   } bundle_type;

   function automatic logic [7:0] cl_char(input logic [3:0] idx);
      logic [7:0] c;
      unique case (idx)
         4'd0: c = "C";
         4'd1: c = "o";
         4'd2: c = "n";
         4'd3: c = "t";
         4'd4: c = "e";
         4'd5: c = "n";
         4'd6: c = "t";
         4'd7: c = "-";
         4'd8: c = "L";
         4'd9: c = "e";
         4'd10: c = "n";
         4'd11: c = "g";
         4'd12: c = "t";
         4'd13: c = "h";
         default: c = 8'd0;
      endcase
      return c;
   endfunction

   function automatic logic [3:0] method_len(input logic [1:0] k);
      logic [3:0] n;
      unique case (k)
         2'd0: n = 4'd4;
         2'd1: n = 4'd3;
         2'd2: n = 4'd6;
         default: n = 4'd0;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] method_char(input logic [1:0] k, input logic [3:0] idx);
      logic [47:0] txt;
      logic [7:0]  c;
      unique case (k)
         2'd0: txt = {"POST", 16'd0};
         2'd1: txt = {"PUT", 24'd0};
         2'd2: txt = "DELETE";
         default: txt = 48'd0;
      endcase
      unique case (idx)
         4'd0: c = txt[47:40];
         4'd1: c = txt[39:32];
         4'd2: c = txt[31:24];
         4'd3: c = txt[23:16];
         4'd4: c = txt[15:8];
         4'd5: c = txt[7:0];
         default: c = 8'd0;
      endcase
      return c;
   endfunction

   function automatic step_type plain_byte(input state_type st_in, input logic [7:0] b);
      step_type    r;
      logic        want;
      logic [36:0] prod;
      r = '0;
      r.st = st_in;
      want = 1'b0;
      prod = '0;
      unique case (st_in.phase)
         PhMethod: begin
            if (b == ChSpace) begin
               for (int k = 0; k < 3; k++) begin
                  if (st_in.method_match[k] && method_len(2'(k)) == st_in.name_match_index)
                     want = 1'b1;
               end
               r.st.body_wanted = want;
               r.emit = 1'b1;
               r.res = '{kind: KindFieldEnd, field: FieldMethod, out_byte: 8'd0};
               r.st.phase = PhPath;
            end else begin
               for (int k = 0; k < 3; k++) begin
                  if (st_in.name_match_index >= method_len(2'(k)) ||
                      method_char(2'(k), st_in.name_match_index) != b)
                     r.st.method_match[k] = 1'b0;
               end
               if (st_in.name_match_index < NoMatch)
                  r.st.name_match_index = st_in.name_match_index + 4'd1;
               r.emit = 1'b1;
               r.res = '{kind: KindData, field: FieldMethod, out_byte: b};
            end
         end
         PhPath: begin
            r.emit = 1'b1;
            if (b == ChSpace) begin
               r.res = '{kind: KindFieldEnd, field: FieldPath, out_byte: 8'd0};
               r.st.phase = PhVersion;
            end else if (b == ChQuestion) begin
               r.res = '{kind: KindFieldEnd, field: FieldPath, out_byte: 8'd0};
               r.st.phase = PhQuery;
            end else begin
               r.res = '{kind: KindData, field: FieldPath, out_byte: b};
            end
         end
         PhQuery: begin
            r.emit = 1'b1;
            if (b == ChSpace) begin
               r.res = '{kind: KindFieldEnd, field: FieldQuery, out_byte: 8'd0};
               r.st.phase = PhVersion;
            end else begin
               r.res = '{kind: KindData, field: FieldQuery, out_byte: b};
            end
         end
         PhName: begin
            r.st.line_empty = 1'b0;
            r.emit = 1'b1;
            if (b == ChColon) begin
               if (st_in.name_match_index == ClLen) begin
                  r.st.length_present = 1'b0;
                  r.st.length_bad = 1'b0;
                  r.st.length_value = 33'd0;
               end
               r.res = '{kind: KindFieldEnd, field: FieldName, out_byte: 8'd0};
               r.st.phase = PhSkip;
               r.st.skip_count = 2'd2;
            end else begin
               if (st_in.name_match_index < ClLen && cl_char(st_in.name_match_index) == b)
                  r.st.name_match_index = st_in.name_match_index + 4'd1;
               else
                  r.st.name_match_index = NoMatch;
               r.res = '{kind: KindData, field: FieldName, out_byte: b};
            end
         end
         PhSkip: begin
            r.st.skip_count = st_in.skip_count - 2'd1;
            if (r.st.skip_count == 2'd0)
               r.st.phase = PhValue;
         end
         PhValue: begin
            if (st_in.name_match_index == ClLen) begin
               r.st.length_present = 1'b1;
               if (b >= ChZero && b <= ChNine) begin
                  prod = {1'b0, st_in.length_value, 3'b000} +
                         {3'b000, st_in.length_value, 1'b0} +
                         {29'd0, b - ChZero};
                  if (prod > {4'd0, LenSat})
                     r.st.length_value = LenSat;
                  else
                     r.st.length_value = prod[32:0];
               end else begin
                  r.st.length_bad = 1'b1;
               end
            end
            r.emit = 1'b1;
            r.res = '{kind: KindData, field: FieldValue, out_byte: b};
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic step_type line_end(input state_type st_in, input logic [31:0] max_len);
      step_type r;
      r = '0;
      r.st = st_in;
      unique case (st_in.phase)
         PhVersion: begin
            r.st.phase = PhName;
            r.st.line_empty = 1'b1;
            r.st.name_match_index = 4'd0;
         end
         PhSkip, PhValue: begin
            r.emit = 1'b1;
            r.res = '{kind: KindFieldEnd, field: FieldValue, out_byte: 8'd0};
            r.st.phase = PhName;
            r.st.line_empty = 1'b1;
            r.st.name_match_index = 4'd0;
         end
         PhName: begin
            r.emit = 1'b1;
            if (!st_in.line_empty) begin
               r.res = '{kind: KindError, field: FieldMethod, out_byte: 8'd0};
               r.st.phase = PhError;
            end else if (st_in.body_wanted && st_in.length_present) begin
               if (st_in.length_bad || st_in.length_value > {1'b0, max_len}) begin
                  r.res = '{kind: KindError, field: FieldMethod, out_byte: 8'd0};
                  r.st.phase = PhError;
               end else if (st_in.length_value == 33'd0) begin
                  r.res = '{kind: KindDone, field: FieldMethod, out_byte: 8'd0};
                  r.st.phase = PhDone;
               end else begin
                  r.emit = 1'b0;
                  r.st.body_remaining = st_in.length_value[31:0];
                  r.st.phase = PhBody;
               end
            end else begin
               r.res = '{kind: KindDone, field: FieldMethod, out_byte: 8'd0};
               r.st.phase = PhDone;
            end
         end
         default: begin
            r.emit = 1'b1;
            r.res = '{kind: KindError, field: FieldMethod, out_byte: 8'd0};
            r.st.phase = PhError;
         end
      endcase
      return r;
   endfunction

endpackage

@@ design/hrsp_if.sv @@
interface hrsp_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] in_byte;

   modport source(output valid, output opcode, output in_byte, input ready);
   modport sink(input valid, input opcode, input in_byte, output ready);
endinterface

interface hrsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [2:0]  field;
   logic [7:0]  out_byte;
   logic [31:0] body_length;
   logic        last;

   modport source(output valid, output kind, output field, output out_byte,
                  output body_length, output last, input ready);
   modport sink(input valid, input kind, input field, input out_byte,
                input body_length, input last, output ready);
endinterface

@@ design/http_request_stream_parser.sv @@
// Each accepted beat updates the parser state in the cycle it is taken, and its
// results enter a small registered result queue and are offered from there.
// One input beat is accepted per cycle while the queue has room; a beat with three
// results is offered one result at a time through the single result port.
// Synchronous reset returns the parser to the start of a request, empties the queue
// and loads the default maximum body length.
module http_request_stream_parser #(
   parameter int unsigned QUEUE_DEPTH = hrsp_pkg::QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   hrsp_req_if.sink    req_bus,
   hrsp_rsp_if.source  rsp_bus,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);

   hrsp_pkg::state_type  state_ff, state_in;
   logic [31:0]          max_len_ff;
   hrsp_pkg::step_type   s1, s2;
   hrsp_pkg::bundle_type bundle;
   hrsp_pkg::result_type r0, r1;
   logic                 e0, e1;
   logic                 can_push, accept, push;
   logic [7:0]           b;

   always_comb begin
      b = req_bus.in_byte;
      accept = req_bus.valid && req_bus.ready;
      state_in = state_ff;
      bundle = '0;
      s1 = '0;
      s2 = '0;
      r0 = '0;
      r1 = '0;
      e0 = 1'b0;
      e1 = 1'b0;
      if (state_ff.phase == hrsp_pkg::PhBody) begin
         state_in.body_remaining = state_ff.body_remaining - 32'd1;
         bundle.res[0] = '{kind: hrsp_pkg::KindData, field: hrsp_pkg::FieldBody, out_byte: b};
         bundle.count = 2'd1;
         if (state_in.body_remaining == 32'd0) begin
            bundle.res[1] = '{kind: hrsp_pkg::KindFieldEnd, field: hrsp_pkg::FieldBody,
                              out_byte: 8'd0};
            bundle.res[2] = '{kind: hrsp_pkg::KindDone, field: hrsp_pkg::FieldMethod,
                              out_byte: 8'd0};
            bundle.count = 2'd3;
            bundle.blen = state_ff.length_value[31:0];
            state_in.phase = hrsp_pkg::PhDone;
         end
      end else if (state_ff.phase == hrsp_pkg::PhDone || state_ff.phase == hrsp_pkg::PhError) begin
         state_in = state_ff;
      end else if (state_ff.cr_pending) begin
         state_in.cr_pending = 1'b0;
         if (b == hrsp_pkg::ChLf) begin
            s1 = hrsp_pkg::line_end(state_in, max_len_ff);
            state_in = s1.st;
            e0 = s1.emit;
            r0 = s1.res;
         end else begin
            s1 = hrsp_pkg::plain_byte(state_in, hrsp_pkg::ChCr);
            state_in = s1.st;
            e0 = s1.emit;
            r0 = s1.res;
            if (s1.st.phase != hrsp_pkg::PhDone && s1.st.phase != hrsp_pkg::PhError) begin
               if (b == hrsp_pkg::ChCr) begin
                  state_in.cr_pending = 1'b1;
               end else begin
                  s2 = hrsp_pkg::plain_byte(s1.st, b);
                  state_in = s2.st;
                  e1 = s2.emit;
                  r1 = s2.res;
               end
            end
         end
      end else if (b == hrsp_pkg::ChCr) begin
         state_in.cr_pending = 1'b1;
      end else begin
         s1 = hrsp_pkg::plain_byte(state_ff, b);
         state_in = s1.st;
         e0 = s1.emit;
         r0 = s1.res;
      end
      if (state_ff.phase != hrsp_pkg::PhBody) begin
         if (e0) begin
            bundle.res[0] = r0;
            bundle.res[1] = r1;
         end else begin
            bundle.res[0] = r1;
         end
         bundle.count = {1'b0, e0} + {1'b0, e1};
      end
      if (req_bus.opcode)
         state_in = hrsp_pkg::StateReset;
      push = accept && !req_bus.opcode && (bundle.count != 2'd0);
      req_bus.ready = can_push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hrsp_pkg::StateReset;
         max_len_ff <= hrsp_pkg::MaxBodyLengthReset;
      end else begin
         if (accept)
            state_ff <= state_in;
         if (csr_we)
            max_len_ff <= csr_wdata;
      end
   end

   hrsp_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_data(bundle),
      .can_push(can_push),
      .rsp_bus(rsp_bus)
   );

endmodule

@@ design/hrsp_queue.sv @@
module hrsp_queue #(
   parameter int unsigned DEPTH = hrsp_pkg::QueueDepth
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  hrsp_pkg::bundle_type   push_data,
   output logic                   can_push,
   hrsp_rsp_if.source             rsp_bus
);

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);

   hrsp_pkg::bundle_type mem_ff [DEPTH];
   logic [PtrW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [1:0]      sub_ff, sub_in;

   hrsp_pkg::bundle_type head;
   hrsp_pkg::result_type cur;
   logic                 last, fire, pop;

   always_comb begin
      head = mem_ff[rd_ff];
      cur = head.res[sub_ff];
      last = (sub_ff == head.count - 2'd1);
      fire = rsp_bus.valid && rsp_bus.ready;
      pop = fire && last;
      can_push = (count_ff != CntW'(DEPTH));

      rsp_bus.valid = (count_ff != '0);
      rsp_bus.kind = cur.kind;
      rsp_bus.field = cur.field;
      rsp_bus.out_byte = cur.out_byte;
      rsp_bus.body_length = last ? head.blen : 32'd0;
      rsp_bus.last = last;

      wr_in = wr_ff;
      if (push)
         wr_in = (wr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      rd_in = rd_ff;
      if (pop)
         rd_in = (rd_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      count_in = count_ff;
      if (push && !pop)
         count_in = count_ff + 1'b1;
      else if (pop && !push)
         count_in = count_ff - 1'b1;
      sub_in = sub_ff;
      if (fire)
         sub_in = last ? 2'd0 : sub_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
         sub_ff <= 2'd0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
         sub_ff <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule
